[src/dvrt_pkg.sv]
// Shared constants, opcodes and types for the distance-vector route table.
package dvrt_pkg;

   localparam int NUM_DEST_DEFAULT      = 16;
   localparam int NUM_NEIGHBORS_DEFAULT = 8;
   localparam int COST_UNREACH_DEFAULT  = 999999;

   localparam int COST_W = 20;
   localparam int OP_W   = 3;
   localparam int SLOT_W = 3;
   localparam int DEST_W = 4;
   localparam int TICK_W = 16;
   localparam int TMO_W  = 8;

   localparam logic [OP_W-1:0] OP_ADD    = 3'd0;
   localparam logic [OP_W-1:0] OP_ADVERT = 3'd1;
   localparam logic [OP_W-1:0] OP_TICK   = 3'd2;
   localparam logic [OP_W-1:0] OP_COST   = 3'd3;
   localparam logic [OP_W-1:0] OP_QUERY  = 3'd4;

   localparam int TIMEOUT_RESET = 3;

   // One accepted and classified item as it travels from front to back.
   typedef struct packed {
      logic [OP_W-1:0]   opcode;
      logic [SLOT_W-1:0] slot;
      logic [DEST_W-1:0] dest;
      logic [COST_W-1:0] cost;
      logic              first;
      logic              slot_ok;
      logic              dest_ok;
   } item_type;

   localparam int ITEM_W = $bits(item_type);

endpackage

[src/distance_vector_route_table_core.sv]
// Top level of the distance-vector route table: front queue plus table sequencer.
// Per item the sequencer goes from idle straight to the response state for add, query and unused
// opcodes, through the relay step for a later advert entry and the direct-edge step before it for
// a first one, through a walk over all destinations for a cost change (not when the slot is
// bad, absent or down), and through a neighbor scan for a tick, with such a walk per downed link.
// It works one item at a time; a two-entry queue takes items meanwhile. Results cannot be stalled.
// Synchronous active-high reset empties the queue, puts all routes at unreachable and timeout at 3.
module distance_vector_route_table_core #(
   parameter int NUM_DEST      = dvrt_pkg::NUM_DEST_DEFAULT,
   parameter int NUM_NEIGHBORS = dvrt_pkg::NUM_NEIGHBORS_DEFAULT,
   parameter int COST_UNREACH  = dvrt_pkg::COST_UNREACH_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [dvrt_pkg::OP_W-1:0]     req_opcode,
   input  logic [dvrt_pkg::SLOT_W-1:0]   req_neighbor_slot,
   input  logic [dvrt_pkg::DEST_W-1:0]   req_destination,
   input  logic [dvrt_pkg::COST_W-1:0]   req_cost,
   input  logic                          req_first_of_advert,
   input  logic                          csr_we,
   input  logic [dvrt_pkg::TMO_W-1:0]    csr_wdata,
   output logic                          rsp_valid,
   output logic [dvrt_pkg::COST_W-1:0]   rsp_route_cost,
   output logic [dvrt_pkg::SLOT_W-1:0]   rsp_next_hop_slot,
   output logic                          rsp_has_next_hop,
   output logic [dvrt_pkg::COST_W-1:0]   rsp_advertised_cost,
   output logic                          rsp_table_changed
);
   logic               q_valid, q_pop;
   dvrt_pkg::item_type q_item;

   dvrt_front #(.NUM_DEST(NUM_DEST), .NUM_NEIGHBORS(NUM_NEIGHBORS),
                .COST_UNREACH(COST_UNREACH)) u_front (
      .clock, .reset, .start,
      .req_opcode, .req_neighbor_slot, .req_destination, .req_cost, .req_first_of_advert,
      .full(busy), .q_valid, .q_item, .q_pop
   );

   dvrt_back #(.NUM_DEST(NUM_DEST), .NUM_NEIGHBORS(NUM_NEIGHBORS),
               .COST_UNREACH(COST_UNREACH)) u_back (
      .clock, .reset, .csr_we, .csr_wdata, .q_valid, .q_item, .q_pop,
      .rsp_valid, .rsp_route_cost, .rsp_next_hop_slot, .rsp_has_next_hop,
      .rsp_advertised_cost, .rsp_table_changed
   );
endmodule

[src/dvrt_front.sv]
// Front end: accepts items, saturates the cost, range-checks indexes and queues them.
module dvrt_front #(
   parameter int NUM_DEST      = dvrt_pkg::NUM_DEST_DEFAULT,
   parameter int NUM_NEIGHBORS = dvrt_pkg::NUM_NEIGHBORS_DEFAULT,
   parameter int COST_UNREACH  = dvrt_pkg::COST_UNREACH_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [dvrt_pkg::OP_W-1:0]     req_opcode,
   input  logic [dvrt_pkg::SLOT_W-1:0]   req_neighbor_slot,
   input  logic [dvrt_pkg::DEST_W-1:0]   req_destination,
   input  logic [dvrt_pkg::COST_W-1:0]   req_cost,
   input  logic                          req_first_of_advert,
   output logic                          full,
   output logic                          q_valid,
   output dvrt_pkg::item_type            q_item,
   input  logic                          q_pop
);
   localparam logic [dvrt_pkg::COST_W-1:0] UNR = dvrt_pkg::COST_W'(COST_UNREACH);

   // Two-entry queue.
   dvrt_pkg::item_type ent_ff [2];
   dvrt_pkg::item_type ent_in [2];
   logic [1:0] cnt_ff, cnt_in;
   logic       push;
   dvrt_pkg::item_type cls;

   always_comb begin
      cls.opcode  = req_opcode;
      cls.slot    = req_neighbor_slot;
      cls.dest    = req_destination;
      cls.cost    = (req_cost >= UNR) ? UNR : req_cost;
      cls.first   = req_first_of_advert;
      cls.slot_ok = 32'(req_neighbor_slot) < NUM_NEIGHBORS;
      cls.dest_ok = 32'(req_destination) < NUM_DEST;
   end

   assign full    = (cnt_ff == 2'd2);
   assign push    = start && !full;
   assign q_valid = (cnt_ff != 2'd0);
   assign q_item  = ent_ff[0];

   always_comb begin
      ent_in[0] = ent_ff[0];
      ent_in[1] = ent_ff[1];
      cnt_in    = cnt_ff;
      if (q_pop) begin
         ent_in[0] = ent_ff[1];
      end
      if (push) begin
         if (q_pop) begin
            // A push with a pop only happens with one item held, so the new item is at the head.
            ent_in[0] = cls;
         end else begin
            ent_in[cnt_ff[0]] = cls;
         end
      end
      cnt_in = cnt_ff + {1'b0, push} - {1'b0, q_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= 2'd0;
      end else begin
         cnt_ff <= cnt_in;
      end
      ent_ff[0] <= ent_in[0];
      ent_ff[1] <= ent_in[1];
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= 2'd2) else $error("queue count out of range");
   a_pop_valid: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> q_valid) else $error("pop from empty queue");
   a_full_no_push: assert property (@(posedge clock) disable iff (reset)
      full |=> cnt_ff != 2'd0) else $error("full queue emptied at once");
endmodule

[src/dvrt_back.sv]
// Back end: a sequencer that applies one item to the route and neighbor tables.
module dvrt_back #(
   parameter int NUM_DEST      = dvrt_pkg::NUM_DEST_DEFAULT,
   parameter int NUM_NEIGHBORS = dvrt_pkg::NUM_NEIGHBORS_DEFAULT,
   parameter int COST_UNREACH  = dvrt_pkg::COST_UNREACH_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_we,
   input  logic [dvrt_pkg::TMO_W-1:0]    csr_wdata,
   input  logic                          q_valid,
   input  dvrt_pkg::item_type            q_item,
   output logic                          q_pop,
   output logic                          rsp_valid,
   output logic [dvrt_pkg::COST_W-1:0]   rsp_route_cost,
   output logic [dvrt_pkg::SLOT_W-1:0]   rsp_next_hop_slot,
   output logic                          rsp_has_next_hop,
   output logic [dvrt_pkg::COST_W-1:0]   rsp_advertised_cost,
   output logic                          rsp_table_changed
);
   localparam int CW = dvrt_pkg::COST_W;
   localparam int SW = dvrt_pkg::SLOT_W;
   localparam int DW = dvrt_pkg::DEST_W;
   localparam int TW = dvrt_pkg::TICK_W;
   localparam int NDI = (NUM_DEST > 1) ? $clog2(NUM_DEST) : 1;
   localparam int NNI = (NUM_NEIGHBORS > 1) ? $clog2(NUM_NEIGHBORS) : 1;
   localparam logic [CW-1:0] UNR = CW'(COST_UNREACH);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_DIR   = 3'd1;
   localparam logic [2:0] S_REL   = 3'd2;
   localparam logic [2:0] S_TSCAN = 3'd3;
   localparam logic [2:0] S_REBAS = 3'd4;
   localparam logic [2:0] S_RESP  = 3'd5;

   // Route table in flip-flops; reset puts every route at unreachable.
   logic [CW-1:0] rc_ff [NUM_DEST];
   logic [SW-1:0] rh_ff [NUM_DEST];
   logic          rv_ff [NUM_DEST];
   logic [DW-1:0] nd_ff [NUM_NEIGHBORS];
   logic [CW-1:0] nl_ff [NUM_NEIGHBORS];
   logic [CW-1:0] no_ff [NUM_NEIGHBORS];
   logic [TW-1:0] nh_ff [NUM_NEIGHBORS];
   logic          np_ff [NUM_NEIGHBORS];
   logic [TW-1:0] tick_ff;
   logic          chg_ff;
   logic [dvrt_pkg::TMO_W-1:0] tmo_ff;

   logic [2:0]          st_ff;
   dvrt_pkg::item_type  it_ff;
   logic [NNI:0]        ncnt_ff;   // neighbor scan position during a tick
   logic [NDI:0]        dcnt_ff;   // destination walk during a re-base
   logic [SW-1:0]       rslot_ff;
   logic [CW-1:0]       rold_ff, rnew_ff;
   logic                rtick_ff;  // re-base was started by the tick scan

   logic [NNI-1:0] s;
   logic [NDI-1:0] di, ndi, wi;
   logic [NNI-1:0] ni, rsi;
   logic           live;
   logic [CW:0]    sum;
   logic [CW-1:0]  t;
   logic [CW+1:0]  rb;
   logic [CW-1:0]  rbc;
   logic [TW-1:0]  silent;
   logic [DW-1:0]  nbr_dest;
   logic           nbr_dest_ok;

   assign s      = NNI'(it_ff.slot);
   assign di     = NDI'(it_ff.dest);
   assign ni     = ncnt_ff[NNI-1:0];
   assign wi     = dcnt_ff[NDI-1:0];
   assign rsi    = NNI'(rslot_ff);
   assign live   = it_ff.slot_ok && np_ff[s];
   assign nbr_dest    = nd_ff[s];
   assign nbr_dest_ok = 32'(nbr_dest) < NUM_DEST;
   assign ndi    = NDI'(nbr_dest);
   assign sum    = {1'b0, nl_ff[s]} + {1'b0, it_ff.cost};
   assign t      = (sum >= {1'b0, UNR}) ? UNR : sum[CW-1:0];
   assign rb     = {2'b00, rc_ff[wi]} - {2'b00, rold_ff} + {2'b00, rnew_ff};
   assign rbc    = rb[CW+1] ? '0 : ((rb[CW:0] >= {1'b0, UNR}) ? UNR : rb[CW-1:0]);
   assign silent = tick_ff - nh_ff[ni];
   assign q_pop  = (st_ff == S_IDLE) && q_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff     <= S_IDLE;
         tick_ff   <= '0;
         chg_ff    <= 1'b0;
         tmo_ff    <= dvrt_pkg::TMO_W'(dvrt_pkg::TIMEOUT_RESET);
         rsp_valid <= 1'b0;
         for (int i = 0; i < NUM_DEST; i++) begin
            rc_ff[i] <= UNR;
            rh_ff[i] <= '0;
            rv_ff[i] <= 1'b0;
         end
         for (int i = 0; i < NUM_NEIGHBORS; i++) begin
            nd_ff[i] <= '0;
            nl_ff[i] <= UNR;
            no_ff[i] <= UNR;
            nh_ff[i] <= '0;
            np_ff[i] <= 1'b0;
         end
      end else begin
         rsp_valid <= 1'b0;
         if (csr_we) begin
            tmo_ff <= csr_wdata;
         end
         case (st_ff)
            S_IDLE: begin
               if (q_valid) begin
                  it_ff <= q_item;
                  case (q_item.opcode)
                     dvrt_pkg::OP_ADD: begin
                        if (q_item.slot_ok) begin
                           np_ff[NNI'(q_item.slot)] <= 1'b1;
                           nd_ff[NNI'(q_item.slot)] <= q_item.dest;
                           nl_ff[NNI'(q_item.slot)] <= q_item.cost;
                           no_ff[NNI'(q_item.slot)] <= q_item.cost;
                           nh_ff[NNI'(q_item.slot)] <= tick_ff;
                           if (q_item.dest_ok) begin
                              rc_ff[NDI'(q_item.dest)] <= q_item.cost;
                              rh_ff[NDI'(q_item.dest)] <= q_item.slot;
                              rv_ff[NDI'(q_item.dest)] <= 1'b1;
                           end
                        end
                        st_ff <= S_RESP;
                     end
                     dvrt_pkg::OP_ADVERT: begin
                        st_ff <= q_item.first ? S_DIR : S_REL;
                     end
                     dvrt_pkg::OP_TICK: begin
                        tick_ff <= tick_ff + 1'b1;
                        ncnt_ff <= '0;
                        st_ff   <= S_TSCAN;
                     end
                     dvrt_pkg::OP_COST: begin
                        st_ff    <= S_RESP;
                        rslot_ff <= q_item.slot;
                        rnew_ff  <= q_item.cost;
                        rold_ff  <= nl_ff[NNI'(q_item.slot)];
                        rtick_ff <= 1'b0;
                        dcnt_ff  <= '0;
                        if (q_item.slot_ok && np_ff[NNI'(q_item.slot)] &&
                            nl_ff[NNI'(q_item.slot)] != UNR) begin
                           st_ff <= S_REBAS;
                        end
                     end
                     default: begin
                        st_ff <= S_RESP;
                     end
                  endcase
               end
            end
            S_DIR: begin
               // First entry: clear flag, restore link, refresh, direct edge.
               st_ff <= S_REL;
               if (live) begin
                  chg_ff <= 1'b0;
                  if (nl_ff[s] >= UNR) begin
                     nl_ff[s] <= no_ff[s];
                  end
                  nh_ff[s] <= tick_ff;
                  if (nbr_dest_ok) begin
                     if ((rv_ff[ndi] && rh_ff[ndi] == it_ff.slot) ||
                         ((nl_ff[s] >= UNR ? no_ff[s] : nl_ff[s]) < rc_ff[ndi])) begin
                        if (rc_ff[ndi] != (nl_ff[s] >= UNR ? no_ff[s] : nl_ff[s])) begin
                           chg_ff <= 1'b1;
                        end
                        rc_ff[ndi] <= (nl_ff[s] >= UNR) ? no_ff[s] : nl_ff[s];
                        rh_ff[ndi] <= it_ff.slot;
                        rv_ff[ndi] <= 1'b1;
                     end
                  end
               end
            end
            S_REL: begin
               st_ff <= S_RESP;
               if (live && it_ff.dest_ok) begin
                  if ((rv_ff[di] && rh_ff[di] == it_ff.slot) || t < rc_ff[di]) begin
                     if (rc_ff[di] != t) begin
                        chg_ff <= 1'b1;
                     end
                     rc_ff[di] <= t;
                     rh_ff[di] <= it_ff.slot;
                     rv_ff[di] <= 1'b1;
                  end
               end
            end
            S_TSCAN: begin
               if (32'(ncnt_ff) >= NUM_NEIGHBORS) begin
                  st_ff <= S_RESP;
               end else begin
                  ncnt_ff <= ncnt_ff + 1'b1;
                  if (np_ff[ni] && silent > TW'(tmo_ff) && nl_ff[ni] != UNR) begin
                     rslot_ff <= SW'(ni);
                     rold_ff  <= nl_ff[ni];
                     rnew_ff  <= UNR;
                     rtick_ff <= 1'b1;
                     dcnt_ff  <= '0;
                     st_ff    <= S_REBAS;
                  end
               end
            end
            S_REBAS: begin
               if (32'(dcnt_ff) >= NUM_DEST) begin
                  nl_ff[rsi] <= rnew_ff;
                  if (!rtick_ff) begin
                     no_ff[rsi] <= rnew_ff;
                  end
                  st_ff <= rtick_ff ? S_TSCAN : S_RESP;
               end else begin
                  dcnt_ff <= dcnt_ff + 1'b1;
                  if (rv_ff[wi] && rh_ff[wi] == rslot_ff) begin
                     rc_ff[wi] <= (rc_ff[wi] >= UNR || rnew_ff >= UNR) ? UNR : rbc;
                  end
               end
            end
            S_RESP: begin
               st_ff     <= S_IDLE;
               rsp_valid <= 1'b1;
            end
            default: begin
               st_ff <= S_IDLE;
            end
         endcase
      end
   end

   // Result fields are captured with the strobe.
   always_ff @(posedge clock) begin
      if (st_ff == S_RESP) begin
         rsp_table_changed <= chg_ff;
         if (it_ff.dest_ok) begin
            rsp_route_cost      <= rc_ff[di];
            rsp_next_hop_slot   <= rv_ff[di] ? rh_ff[di] : '0;
            rsp_has_next_hop    <= rv_ff[di];
            rsp_advertised_cost <= (rv_ff[di] && rh_ff[di] == it_ff.slot) ? UNR : rc_ff[di];
         end else begin
            rsp_route_cost      <= UNR;
            rsp_next_hop_slot   <= '0;
            rsp_has_next_hop    <= 1'b0;
            rsp_advertised_cost <= UNR;
         end
      end
   end

   a_one_resp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid) else $error("back-to-back responses");
   a_resp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> st_ff == S_IDLE) else $error("response outside idle");
   a_pop_resp: assert property (@(posedge clock) disable iff (reset)
      q_pop |=> !rsp_valid) else $error("response right after pop");
   a_adv_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_advertised_cost <= UNR) else $error("cost above unreachable");
endmodule

[dv/distance_vector_route_table_core_test.sv]
// Self-checking testbench for the distance-vector route table core.
`timescale 1ns / 100ps

module distance_vector_route_table_core_test;
   localparam int COST_W = dvrt_pkg::COST_W;
   localparam int OP_W   = dvrt_pkg::OP_W;
   localparam int SLOT_W = dvrt_pkg::SLOT_W;
   localparam int DEST_W = dvrt_pkg::DEST_W;
   localparam int TICK_W = dvrt_pkg::TICK_W;
   localparam int TMO_W  = dvrt_pkg::TMO_W;
   localparam int ND = dvrt_pkg::NUM_DEST_DEFAULT;
   localparam int NN = dvrt_pkg::NUM_NEIGHBORS_DEFAULT;
   localparam logic [COST_W-1:0] UNREACH = COST_W'(dvrt_pkg::COST_UNREACH_DEFAULT);
   localparam int CYCLE_LIMIT = 600000;
   localparam logic [OP_W-1:0] OP_SPARE5 = 3'd5;
   localparam logic [OP_W-1:0] OP_SPARE6 = 3'd6;
   localparam logic [OP_W-1:0] OP_SPARE7 = 3'd7;

   typedef struct {
      logic [COST_W-1:0] route_cost;
      logic [SLOT_W-1:0] next_hop;
      logic              has_hop;
      logic [COST_W-1:0] adv_cost;
      logic              changed;
   } route_answer_type;

   class route_table_scoreboard;
      logic [COST_W-1:0] rcost[ND];
      logic [SLOT_W-1:0] rhop[ND];
      bit                rhas[ND];
      logic [DEST_W-1:0] nb_dest[NN];
      logic [COST_W-1:0] nb_live[NN];
      logic [COST_W-1:0] nb_orig[NN];
      logic [TICK_W-1:0] nb_heard[NN];
      bit                nb_present[NN];
      logic [TICK_W-1:0] ticks;
      bit                changed;
      logic [TMO_W-1:0]  timeout;
      route_answer_type  pending[$];
      int                errors;

      function new();
         for (int i = 0; i < ND; i++) begin
            rcost[i] = UNREACH;
            rhop[i] = '0;
            rhas[i] = 0;
         end
         for (int i = 0; i < NN; i++) begin
            nb_dest[i] = '0;
            nb_live[i] = UNREACH;
            nb_orig[i] = UNREACH;
            nb_heard[i] = '0;
            nb_present[i] = 0;
         end
         ticks = '0;
         changed = 0;
         timeout = TMO_W'(dvrt_pkg::TIMEOUT_RESET);
         errors = 0;
      endfunction

      function logic [COST_W-1:0] clamp(longint c);
         return (c >= longint'(UNREACH)) ? UNREACH : COST_W'(c);
      endfunction

      function bit via(int d, int s);
         return rhas[d] && rhop[d] == s;
      endfunction

      function void take(int d, int s, logic [COST_W-1:0] c);
         if (rcost[d] != c) changed = 1;
         rcost[d] = c;
         rhop[d] = SLOT_W'(s);
         rhas[d] = 1;
      endfunction

      // Re-base every route through the slot onto a new link cost.
      function void relink(int s, logic [COST_W-1:0] c);
         longint v;
         logic [COST_W-1:0] old;
         old = nb_live[s];
         nb_live[s] = c;
         for (int d = 0; d < ND; d++) begin
            if (via(d, s)) begin
               if (rcost[d] >= UNREACH || c >= UNREACH) begin
                  rcost[d] = UNREACH;
               end else begin
                  v = longint'(rcost[d]) - longint'(old) + longint'(c);
                  if (v < 0) v = 0;
                  rcost[d] = clamp(v);
               end
            end
         end
      endfunction

      function void note_item(logic [OP_W-1:0] op, int s, int d, logic [COST_W-1:0] raw,
                              bit first);
         logic [COST_W-1:0] c;
         logic [TICK_W-1:0] silent;
         route_answer_type a;
         c = clamp(longint'(raw));
         case (op)
            dvrt_pkg::OP_ADD: begin
               nb_present[s] = 1;
               nb_dest[s] = DEST_W'(d);
               nb_live[s] = c;
               nb_orig[s] = c;
               nb_heard[s] = ticks;
               rcost[d] = c;
               rhop[d] = SLOT_W'(s);
               rhas[d] = 1;
            end
            dvrt_pkg::OP_ADVERT: begin
               if (nb_present[s]) begin
                  if (first) begin
                     changed = 0;
                     if (nb_live[s] >= UNREACH) nb_live[s] = nb_orig[s];
                     nb_heard[s] = ticks;
                     if (via(int'(nb_dest[s]), s) || nb_live[s] < rcost[nb_dest[s]])
                        take(int'(nb_dest[s]), s, nb_live[s]);
                  end
                  if (via(d, s) || clamp(longint'(nb_live[s]) + longint'(c)) < rcost[d])
                     take(d, s, clamp(longint'(nb_live[s]) + longint'(c)));
               end
            end
            dvrt_pkg::OP_TICK: begin
               ticks = ticks + 1'b1;
               for (int i = 0; i < NN; i++) begin
                  silent = ticks - nb_heard[i];
                  if (nb_present[i] && silent > timeout && nb_live[i] != UNREACH)
                     relink(i, UNREACH);
               end
            end
            dvrt_pkg::OP_COST: begin
               if (nb_present[s] && nb_live[s] != UNREACH) begin
                  relink(s, c);
                  nb_orig[s] = c;
               end
            end
            default: ;
         endcase
         a.route_cost = rcost[d];
         a.next_hop = rhas[d] ? rhop[d] : '0;
         a.has_hop = rhas[d];
         a.adv_cost = via(d, s) ? UNREACH : rcost[d];
         a.changed = changed;
         pending.insert(pending.size(), a);
      endfunction

      task report(string what, logic [COST_W-1:0] got, logic [COST_W-1:0] want);
         $display("mismatch at %0t: %s got %0d expected %0d", $time, what, got, want);
         errors++;
      endtask

      task check_result(route_answer_type got);
         route_answer_type want;
         if (pending.size() == 0) begin
            report("unexpected result, route_cost", got.route_cost, '0);
         end else begin
            want = pending.pop_front();
            if (got.route_cost !== want.route_cost)
               report("route_cost", got.route_cost, want.route_cost);
            if (got.next_hop !== want.next_hop)
               report("next_hop_slot", COST_W'(got.next_hop), COST_W'(want.next_hop));
            if (got.has_hop !== want.has_hop)
               report("has_next_hop", COST_W'(got.has_hop), COST_W'(want.has_hop));
            if (got.adv_cost !== want.adv_cost)
               report("advertised_cost", got.adv_cost, want.adv_cost);
            if (got.changed !== want.changed)
               report("table_changed", COST_W'(got.changed), COST_W'(want.changed));
         end
      endtask
   endclass

   logic clock, reset, start, busy, csr_we;
   logic [OP_W-1:0]   req_opcode;
   logic [SLOT_W-1:0] req_neighbor_slot;
   logic [DEST_W-1:0] req_destination;
   logic [COST_W-1:0] req_cost;
   logic              req_first_of_advert;
   logic [TMO_W-1:0]  csr_wdata;
   logic              rsp_valid, rsp_has_next_hop, rsp_table_changed;
   logic [COST_W-1:0] rsp_route_cost, rsp_advertised_cost;
   logic [SLOT_W-1:0] rsp_next_hop_slot;

   route_table_scoreboard sb = new();
   int cycles = 0;
   bit idling_on = 1;

   distance_vector_route_table_core dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_opcode(req_opcode), .req_neighbor_slot(req_neighbor_slot),
      .req_destination(req_destination), .req_cost(req_cost),
      .req_first_of_advert(req_first_of_advert),
      .csr_we(csr_we), .csr_wdata(csr_wdata),
      .rsp_valid(rsp_valid), .rsp_route_cost(rsp_route_cost),
      .rsp_next_hop_slot(rsp_next_hop_slot), .rsp_has_next_hop(rsp_has_next_hop),
      .rsp_advertised_cost(rsp_advertised_cost), .rsp_table_changed(rsp_table_changed)
   );

   initial begin
      clock = 0;
      forever #1 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   always @(posedge clock) begin
      route_answer_type got;
      if (!reset && rsp_valid) begin
         got.route_cost = rsp_route_cost;
         got.next_hop = rsp_next_hop_slot;
         got.has_hop = rsp_has_next_hop;
         got.adv_cost = rsp_advertised_cost;
         got.changed = rsp_table_changed;
         sb.check_result(got);
      end
   end

   // Presents one item until an edge accepts it, then keeps start high or drops it for a random idle gap.
   task send_item(logic [OP_W-1:0] op, int s, int d, logic [COST_W-1:0] c, bit first);
      start <= 1'b1;
      req_opcode <= op;
      req_neighbor_slot <= SLOT_W'(s);
      req_destination <= DEST_W'(d);
      req_cost <= c;
      req_first_of_advert <= first;
      @(posedge clock);
      while (busy) @(posedge clock);
      sb.note_item(op, s, d, c, first);
      if (idling_on && $urandom_range(0, 3) == 0) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 7)) @(posedge clock);
      end
   endtask

   task wait_drained();
      start <= 1'b0;
      @(posedge clock);
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   task write_timeout(logic [TMO_W-1:0] v);
      wait_drained();
      csr_we <= 1'b1;
      csr_wdata <= v;
      @(posedge clock);
      csr_we <= 1'b0;
      sb.timeout = v;
   endtask

   function logic [COST_W-1:0] pick_cost();
      case ($urandom_range(0, 5))
         0, 1: return COST_W'($urandom_range(0, 60));
         2: return UNREACH;
         3: return COST_W'($urandom_range(dvrt_pkg::COST_UNREACH_DEFAULT, (1 << COST_W) - 1));
         4: return COST_W'($urandom_range(0, 2000));
         default: return COST_W'($urandom);
      endcase
   endfunction

   // Mostly well-formed traffic: neighbor setup, whole advertisements, ticks, cost changes, queries, random opcodes.
   task random_items(int count);
      int n, s, entries;
      n = 0;
      while (n < count) begin
         s = $urandom_range(0, NN - 1);
         case ($urandom_range(0, 19))
            0, 1, 2: begin
               send_item(dvrt_pkg::OP_ADD, s, $urandom_range(0, ND - 1), pick_cost(),
                         1'($urandom));
               n++;
            end
            3, 4, 5, 6, 7, 8, 9, 10: begin
               entries = $urandom_range(0, 4);
               send_item(dvrt_pkg::OP_ADVERT, s, $urandom_range(0, ND - 1), pick_cost(),
                         1'b1);
               n++;
               for (int k = 0; k < entries; k++) begin
                  send_item(dvrt_pkg::OP_ADVERT, s, $urandom_range(0, ND - 1), pick_cost(),
                            1'b0);
                  n++;
               end
            end
            11, 12: begin
               send_item(dvrt_pkg::OP_TICK, s, $urandom_range(0, ND - 1), pick_cost(),
                         1'($urandom));
               n++;
            end
            13, 14: begin
               send_item(dvrt_pkg::OP_COST, s, $urandom_range(0, ND - 1), pick_cost(),
                         1'($urandom));
               n++;
            end
            15, 16, 17: begin
               send_item(dvrt_pkg::OP_QUERY, s, $urandom_range(0, ND - 1), pick_cost(),
                         1'($urandom));
               n++;
            end
            default: begin
               send_item(OP_W'($urandom), s, $urandom_range(0, ND - 1), COST_W'($urandom),
                         1'($urandom));
               n++;
            end
         endcase
      end
   endtask

   initial begin
      reset <= 1'b1;
      start <= 1'b0;
      csr_we <= 1'b0;
      csr_wdata <= '0;
      req_opcode <= dvrt_pkg::OP_QUERY;
      req_neighbor_slot <= '0;
      req_destination <= '0;
      req_cost <= '0;
      req_first_of_advert <= 1'b0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part under the reset timeout.
      send_item(dvrt_pkg::OP_QUERY, 0, 0, '0, 1'b0);
      send_item(dvrt_pkg::OP_ADD, 0, 0, '0, 1'b0);
      send_item(dvrt_pkg::OP_ADD, 7, 15, UNREACH, 1'b1);
      send_item(dvrt_pkg::OP_ADD, 1, 3, 20'd5, 1'b0);
      send_item(dvrt_pkg::OP_ADVERT, 5, 2, 20'd1, 1'b1);
      send_item(dvrt_pkg::OP_ADVERT, 1, 5, 20'd10, 1'b1);
      send_item(dvrt_pkg::OP_ADVERT, 1, 15, '1, 1'b0);
      send_item(dvrt_pkg::OP_ADVERT, 1, 0, 20'd0, 1'b0);
      send_item(dvrt_pkg::OP_COST, 1, 5, 20'd7, 1'b0);
      send_item(dvrt_pkg::OP_COST, 4, 5, 20'd1, 1'b0);
      send_item(dvrt_pkg::OP_COST, 1, 3, 20'd0, 1'b0);
      send_item(dvrt_pkg::OP_QUERY, 1, 5, '0, 1'b0);
      for (int k = 0; k < 5; k++) send_item(dvrt_pkg::OP_TICK, 0, 5, '0, 1'b0);
      send_item(dvrt_pkg::OP_COST, 1, 5, 20'd3, 1'b0);
      send_item(dvrt_pkg::OP_ADVERT, 1, 6, 20'd999998, 1'b1);
      send_item(dvrt_pkg::OP_QUERY, 0, 6, '1, 1'b1);
      send_item(OP_SPARE5, 2, 3, '1, 1'b1);
      send_item(OP_SPARE6, 3, 15, '0, 1'b0);
      send_item(OP_SPARE7, 6, 0, 20'h55555, 1'b1);
      send_item(dvrt_pkg::OP_QUERY, 7, 15, 20'haaaaa, 1'b0);

      // The sender holds off here until every result is back.
      write_timeout('0);
      random_items(100);
      write_timeout(8'hff);
      random_items(100);
      write_timeout(8'd1);
      random_items(100);
      write_timeout(TMO_W'($urandom));
      idling_on = 0;
      random_items(100);

      wait_drained();
      if (sb.pending.size() != 0) begin
         $display("leftover expectations: %0d", sb.pending.size());
         sb.errors++;
      end
      if (sb.errors == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end
endmodule

[files.f]
src/dvrt_pkg.sv
src/dvrt_front.sv
src/dvrt_back.sv
src/distance_vector_route_table_core.sv
dv/distance_vector_route_table_core_test.sv
